// ===== src/ssfd_pkg.sv =====
// Shared constants, types and codes for the stiff string time-step block.
// No dependencies; compiled first.
package ssfd_pkg;

  localparam int MAX_POINTS = 2048;
  localparam int MIN_POINTS = 5;
  localparam int DISP_W     = 32;   // stored displacement, Q4.28
  localparam int IO_W       = 32;   // displacement fields on the channels
  localparam int COEF_W     = 32;   // coefficients, unsigned Q8.24
  localparam int FRAC_W     = 24;   // coefficient fraction bits
  localparam int IDX_W      = 11;   // point_index / pickup_index field
  localparam int LEN_W      = 12;   // active_length field
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 2);

  // datapath widths, all derived from the displacement and coefficient widths
  localparam int D2_W   = DISP_W + 3;
  localparam int D4_W   = DISP_W + 5;
  localparam int D2H_W  = D2_W - FRAC_W;
  localparam int D4H_W  = D4_W - FRAC_W;
  localparam int PHW_W  = COEF_W + 1 + D2H_W;
  localparam int PHS_W  = COEF_W + 1 + D4H_W;
  localparam int PL_W   = COEF_W + FRAC_W;
  localparam int HI_W   = PHS_W + 1;
  localparam int LO_W   = PL_W + 2;
  localparam int CP_W   = DISP_W + 2;
  localparam int SUM_W  = HI_W + 3;
  localparam int HALF_LSB = 1 << (FRAC_W - 1);

  localparam logic [COEF_W-1:0] WAVE_RST   = COEF_W'(4194304);
  localparam logic [COEF_W-1:0] STIFF_RST  = '0;
  localparam logic [IDX_W-1:0]  PICKUP_RST = IDX_W'(1433);
  localparam logic [LEN_W-1:0]  LENGTH_RST = LEN_W'(2048);

  typedef logic signed [DISP_W-1:0] disp_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } ssfd_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVE   = 2'd0,
    REG_STIFF  = 2'd1,
    REG_PICKUP = 2'd2,
    REG_LENGTH = 2'd3
  } ssfd_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_PICK
  } ssfd_state_e;

  // controller -> datapath
  typedef struct packed {
    logic  clr_en;
    addr_t clr_addr;
    logic  load_en;
    logic  step_start;
    logic  rd_en;
    cnt_t  rd_idx;
    logic  out_load;
  } ssfd_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic pipe_busy;
    cnt_t len;
  } ssfd_stat_t;

endpackage

// ===== src/ssfd_intf.sv =====
// Channel interfaces: input items, result items and configuration writes.
// Depends on ssfd_pkg for the field widths.
interface ssfd_in_if;
  import ssfd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [IDX_W-1:0]       point_index;
  logic signed [IO_W-1:0] prev_value;
  logic signed [IO_W-1:0] curr_value;
  modport source (output valid, cmd, point_index, prev_value, curr_value, input ready);
  modport sink   (input valid, cmd, point_index, prev_value, curr_value, output ready);
endinterface

interface ssfd_out_if;
  import ssfd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] pickup_sample;
  logic                   saturated;
  modport source (output valid, pickup_sample, saturated, input ready);
  modport sink   (input valid, pickup_sample, saturated, output ready);
endinterface

interface ssfd_cfg_if;
  import ssfd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/ssfd_ctrl.sv =====
// Sequencer: reset clearing sweep, item intake, point streaming, drain, result.
// Depends on ssfd_pkg.
module ssfd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_cmd_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  input  ssfd_pkg::ssfd_stat_t stat_i,
  output ssfd_pkg::ssfd_ctl_t  ctl_o
);
  import ssfd_pkg::*;

  ssfd_state_e state_q, state_d;
  cnt_t        cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state and point counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + cnt_t'(1);
        if (cnt_q == cnt_t'(MAX_POINTS - 1)) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end
      end
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i && (in_cmd_i == CMD_STEP)) state_d = ST_RUN;
      end
      ST_RUN: begin
        cnt_d = cnt_q + cnt_t'(1);
        if (cnt_q == stat_i.len + cnt_t'(1)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) state_d = ST_PICK;
      end
      ST_PICK: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
        cnt_d   = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctl_o          = '0;
    in_ready_o     = 1'b0;
    ctl_o.clr_addr = cnt_q[ADDR_W-1:0];
    ctl_o.rd_idx   = cnt_q;
    unique case (state_q)
      ST_CLEAR: ctl_o.clr_en = 1'b1;
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        ctl_o.load_en    = in_valid_i && (in_cmd_i == CMD_LOAD);
        ctl_o.step_start = in_valid_i && (in_cmd_i == CMD_STEP);
      end
      ST_RUN:   ctl_o.rd_en = 1'b1;
      ST_DRAIN: ;
      ST_PICK:  ctl_o.out_load = out_free;
      default:  ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.out_load)  out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q <= stat_i.len + cnt_t'(1)))
    else $error("read counter ran past the string end");

  a_result_from_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_PICK))
    else $error("result raised outside the result state");
`endif

endmodule

// ===== src/ssfd_dp.sv =====
// Datapath: config registers, displacement memories, five-point window and
// the stencil / coefficient pipeline with saturation. Depends on ssfd_pkg.
module ssfd_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ssfd_pkg::ssfd_ctl_t           ctl_i,
  output ssfd_pkg::ssfd_stat_t          stat_o,
  input  logic                          cfg_we_i,
  input  logic [ssfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ssfd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [ssfd_pkg::IDX_W-1:0]    ld_index_i,
  input  logic signed [ssfd_pkg::IO_W-1:0] ld_prev_i,
  input  logic signed [ssfd_pkg::IO_W-1:0] ld_curr_i,
  output logic signed [ssfd_pkg::IO_W-1:0] out_sample_o,
  output logic                          out_sat_o
);
  import ssfd_pkg::*;

  // configuration
  logic [COEF_W-1:0] wave_q, stiff_q;
  logic [IDX_W-1:0]  pickup_q;
  logic [LEN_W-1:0]  length_q;
  cnt_t              len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q   <= WAVE_RST;
      stiff_q  <= STIFF_RST;
      pickup_q <= PICKUP_RST;
      length_q <= LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (ssfd_reg_e'(cfg_idx_i))
        REG_WAVE:   wave_q   <= cfg_data_i[COEF_W-1:0];
        REG_STIFF:  stiff_q  <= cfg_data_i[COEF_W-1:0];
        REG_PICKUP: pickup_q <= cfg_data_i[IDX_W-1:0];
        REG_LENGTH: length_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(length_q) < MIN_POINTS)      len = cnt_t'(MIN_POINTS);
    else if (32'(length_q) > MAX_POINTS) len = cnt_t'(MAX_POINTS);
    else                                 len = cnt_t'(length_q);
  end

  // memories
  disp_t curr_mem [MAX_POINTS];
  disp_t prev_mem [MAX_POINTS];
  disp_t curr_rd_q, prev_rd_q;
  logic  mem_we;
  addr_t mem_waddr;
  disp_t mem_wcurr, mem_wprev;
  cnt_t  prev_ridx;

  // stage registers
  logic  s1_vld_q, a_vld_q, b_vld_q, c_vld_q, d_vld_q;
  cnt_t  s1_k_q;
  disp_t win_q [5];
  disp_t pw_q;
  addr_t a_pt_q, b_pt_q, c_pt_q, d_pt_q;

  logic signed [D2H_W-1:0] b_d2h_q;
  logic signed [D4H_W-1:0] b_d4h_q;
  logic [FRAC_W-1:0]       b_d2l_q, b_d4l_q;
  logic signed [CP_W-1:0]  b_cp_q, c_cp_q, d_cp_q;
  disp_t                   b_c0_q, c_c0_q, d_c0_q;

  logic signed [PHW_W-1:0] c_phw_q;
  logic signed [PHS_W-1:0] c_phs_q;
  logic [PL_W-1:0]         c_plw_q, c_pls_q;

  logic signed [HI_W-1:0]  d_hi_q;
  logic signed [LO_W-1:0]  d_lo_q;

  disp_t pick_q, out_sample_q;
  logic  sat_q, out_sat_q;

  // stencil terms (stage A)
  logic signed [DISP_W:0] c0x, neg_c0, l1, l2, r1, r2;
  logic signed [D2_W-1:0] d2;
  logic signed [D4_W-1:0] d4;
  logic signed [CP_W-1:0] cp;
  logic at_first, at_second, at_last, at_penult;

  // result (stage D)
  logic signed [LO_W-1:0]  lo_sh;
  logic signed [SUM_W-1:0] sum;
  logic                    fits;
  disp_t                   next_disp;

  assign prev_ridx = ctl_i.rd_idx - cnt_t'(2);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = d_pt_q;
    mem_wcurr = next_disp;
    mem_wprev = d_c0_q;
    if (ctl_i.clr_en) begin
      mem_we    = 1'b1;
      mem_waddr = ctl_i.clr_addr;
      mem_wcurr = '0;
      mem_wprev = '0;
    end else if (ctl_i.load_en) begin
      mem_we    = 1'b1;
      mem_waddr = ADDR_W'(ld_index_i);
      mem_wcurr = DISP_W'(ld_curr_i);
      mem_wprev = DISP_W'(ld_prev_i);
    end else if (d_vld_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      curr_mem[mem_waddr] <= mem_wcurr;
      prev_mem[mem_waddr] <= mem_wprev;
    end
    if (ctl_i.rd_en) begin
      curr_rd_q <= curr_mem[ctl_i.rd_idx[ADDR_W-1:0]];
      prev_rd_q <= prev_mem[prev_ridx[ADDR_W-1:0]];
    end
  end

  // virtual neighbors beyond the ends: c[-1] = c[n] = 0, c[-2] = -c[0],
  // c[n+1] = -c[n-1]
  always_comb begin
    c0x       = (DISP_W+1)'(win_q[2]);
    neg_c0    = -c0x;
    at_first  = (a_pt_q == '0);
    at_second = (a_pt_q == addr_t'(1));
    at_last   = (cnt_t'(a_pt_q) == len - cnt_t'(1));
    at_penult = (cnt_t'(a_pt_q) == len - cnt_t'(2));
    l1 = at_first ? '0 : (DISP_W+1)'(win_q[1]);
    l2 = at_first ? neg_c0 : (at_second ? '0 : (DISP_W+1)'(win_q[0]));
    r1 = at_last ? '0 : (DISP_W+1)'(win_q[3]);
    r2 = at_last ? neg_c0 : (at_penult ? '0 : (DISP_W+1)'(win_q[4]));
    d2 = D2_W'(l1) + D2_W'(r1) - (D2_W'(c0x) <<< 1);
    d4 = D4_W'(l2) + D4_W'(r2) - (D4_W'(l1) <<< 2) - (D4_W'(r1) <<< 2)
       + (D4_W'(c0x) <<< 2) + (D4_W'(c0x) <<< 1);
    cp = (CP_W'(c0x) <<< 1) - CP_W'(pw_q);
  end

  // round-to-nearest of the coefficient term, then saturate
  always_comb begin
    lo_sh = d_lo_q >>> FRAC_W;
    sum   = SUM_W'(d_hi_q) + SUM_W'(lo_sh) + SUM_W'(d_cp_q);
    fits  = (sum[SUM_W-1:DISP_W-1] == '0) || (sum[SUM_W-1:DISP_W-1] == '1);
    if (fits)             next_disp = sum[DISP_W-1:0];
    else if (sum[SUM_W-1]) next_disp = {1'b1, {(DISP_W-1){1'b0}}};
    else                  next_disp = {1'b0, {(DISP_W-1){1'b1}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
      c_vld_q  <= 1'b0;
      d_vld_q  <= 1'b0;
    end else begin
      s1_vld_q <= ctl_i.rd_en;
      a_vld_q  <= s1_vld_q && (s1_k_q >= cnt_t'(2));
      b_vld_q  <= a_vld_q;
      c_vld_q  <= b_vld_q;
      d_vld_q  <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_k_q <= ctl_i.rd_idx;
    if (s1_vld_q) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= win_q[3];
      win_q[3] <= win_q[4];
      win_q[4] <= curr_rd_q;
      pw_q     <= prev_rd_q;
      a_pt_q   <= ADDR_W'(s1_k_q - cnt_t'(2));
    end
    // stage A -> B
    b_pt_q  <= a_pt_q;
    b_d2h_q <= d2[D2_W-1:FRAC_W];
    b_d2l_q <= d2[FRAC_W-1:0];
    b_d4h_q <= d4[D4_W-1:FRAC_W];
    b_d4l_q <= d4[FRAC_W-1:0];
    b_cp_q  <= cp;
    b_c0_q  <= win_q[2];
    // stage B -> C: split products
    c_pt_q  <= b_pt_q;
    c_phw_q <= $signed({1'b0, wave_q}) * b_d2h_q;
    c_phs_q <= $signed({1'b0, stiff_q}) * b_d4h_q;
    c_plw_q <= wave_q * b_d2l_q;
    c_pls_q <= stiff_q * b_d4l_q;
    c_cp_q  <= b_cp_q;
    c_c0_q  <= b_c0_q;
    // stage C -> D
    d_pt_q  <= c_pt_q;
    d_hi_q  <= HI_W'(c_phw_q) - HI_W'(c_phs_q);
    d_lo_q  <= $signed(LO_W'(c_plw_q)) - $signed(LO_W'(c_pls_q))
             + $signed(LO_W'(HALF_LSB));
    d_cp_q  <= c_cp_q;
    d_c0_q  <= c_c0_q;
    // pickup and saturation flag
    if (ctl_i.step_start) begin
      pick_q <= '0;
      sat_q  <= 1'b0;
    end else if (d_vld_q) begin
      if (32'(d_pt_q) == 32'(pickup_q)) pick_q <= next_disp;
      if (!fits) sat_q <= 1'b1;
    end
    if (ctl_i.out_load) begin
      out_sample_q <= pick_q;
      out_sat_q    <= sat_q;
    end
  end

  assign out_sample_o     = IO_W'(out_sample_q);
  assign out_sat_o        = out_sat_q;
  assign stat_o.len       = len;
  assign stat_o.pipe_busy = s1_vld_q || a_vld_q || b_vld_q || c_vld_q || d_vld_q;

`ifndef SYNTH
  a_wb_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_vld_q |-> (cnt_t'(d_pt_q) < len))
    else $error("write-back beyond active length");

  a_start_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.step_start || ctl_i.load_en) |-> !stat_o.pipe_busy)
    else $error("new item while the pipeline is busy");

  a_clear_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clr_en |-> (!ctl_i.rd_en && !d_vld_q && !ctl_i.load_en))
    else $error("clearing sweep overlaps other memory traffic");
`endif

endmodule

// ===== src/stiff_string_fd_step.sv =====
// Top level of the stiff string finite-difference time-step block.
// Depends on ssfd_pkg, the channel interfaces, ssfd_ctrl and ssfd_dp.
//
// Usage:
//   in_i  : items. cmd = load writes prev/curr displacement of point_index
//           (no result). cmd = step advances every point of the
//           active length and returns one item on out_o.
//   out_o : pickup_sample (new displacement at pickup_index, 0 if the pickup
//           lies beyond the active length) and saturated (any point clipped).
//   cfg_i : register writes, always ready; index 0 wave_coef, 1 stiff_coef,
//           2 pickup_index, 3 active_length. Write only while idle.
// Timing: a step streams one point per cycle through the two displacement
//   memories (one read port each, write-back behind the reads), over the
//   clamped active length n (5..2048). One item is worked on at a time.
// Reset: a clearing sweep zeroes all 2048 entries of both memories, one per
//   cycle; in_i.ready stays low until it ends, config writes are taken.
// Stall: a result waits in the output register; loads are still accepted,
//   a following step finishes and then waits until that register is free.
module stiff_string_fd_step (
  input logic         clk_i,
  input logic         rst_ni,
  ssfd_in_if.sink     in_i,
  ssfd_out_if.source  out_o,
  ssfd_cfg_if.sink    cfg_i
);
  import ssfd_pkg::*;

  ssfd_ctl_t  ctl;
  ssfd_stat_t stat;

  // config port never stalls
  assign cfg_i.ready = 1'b1;

  ssfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.cmd),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  ssfd_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .cfg_we_i     (cfg_i.valid),
    .cfg_idx_i    (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .ld_index_i   (in_i.point_index),
    .ld_prev_i    (in_i.prev_value),
    .ld_curr_i    (in_i.curr_value),
    .out_sample_o (out_o.pickup_sample),
    .out_sat_o    (out_o.saturated)
  );

endmodule

// ===== tb/sv/stiff_string_fd_step_tb.sv =====
// Self-checking testbench for stiff_string_fd_step: drives load and step items,
// writes the coefficient/length/pickup registers between phases, checks results.
// Depends on ssfd_pkg, the channel interfaces in ssfd_intf.sv and stiff_string_fd_step.
module stiff_string_fd_step_tb;
  import ssfd_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int RST_CYCLES = 8;
  // worst case: every item a full-length step, plus stalls
  localparam longint RUN_LIMIT = 80_000_000;
  // spare cycles after the last result before touching registers
  localparam int QUIET_CYCLES = 16;
  // after the last result, wait longer than the longest step takes
  localparam int TAIL_CYCLES = 2 * (MAX_POINTS + 16);
  localparam int HOLD_CYCLES = 400;

  // register values after reset
  localparam logic [COEF_W-1:0] WAVE_INIT   = 32'd4194304;
  localparam logic [COEF_W-1:0] STIFF_INIT  = 32'd0;
  localparam logic [IDX_W-1:0]  PICKUP_INIT = 11'd1433;
  localparam logic [LEN_W-1:0]  LENGTH_INIT = 12'd2048;

  localparam longint DISP_MAX = 64'sd2147483647;
  localparam longint DISP_MIN = -64'sd2147483648;

  // one expected result item
  typedef struct {
    disp_t disp;
    logic  sat;
  } pickup_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  ssfd_in_if  in_if ();
  ssfd_out_if out_if ();
  ssfd_cfg_if cfg_if ();

  stiff_string_fd_step DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // ---------------------------------------------------------------------------
  // String model: both displacement rows and the registers, kept in step with
  // every accepted item and register write.
  // ---------------------------------------------------------------------------
  longint prev_row [MAX_POINTS] = '{default: 0};
  longint curr_row [MAX_POINTS] = '{default: 0};
  longint next_row [MAX_POINTS] = '{default: 0};

  logic [COEF_W-1:0] wave_reg   = WAVE_INIT;
  logic [COEF_W-1:0] stiff_reg  = STIFF_INIT;
  logic [IDX_W-1:0]  pickup_reg = PICKUP_INIT;
  logic [LEN_W-1:0]  len_reg    = LENGTH_INIT;

  pickup_t pickup_q [$];   // results still owed by the block, oldest first
  pickup_t got_exp;

  int idle_pct  = 0;       // sender idles this many cycles in a hundred
  int stall_pct = 0;       // receiver stalls this many cycles in a hundred
  int hold_req  = 0;       // request for a long receiver hold-off
  int hold_left = 0;

  int errors = 0;
  int n_loads = 0;
  int n_steps = 0;
  int n_results = 0;
  int n_sat = 0;
  int n_cfg = 0;

  // active length as the block uses it
  function automatic int eff_len(logic [LEN_W-1:0] l);
    if (l < MIN_POINTS) return MIN_POINTS;
    if (l > MAX_POINTS) return MAX_POINTS;
    return int'(l);
  endfunction

  // current row with the simply supported (hinged) ghost points outside [0, n)
  function automatic longint curr_at(int j, int n);
    if (j == -1 || j == n) return 0;
    if (j == -2) return -curr_row[0];
    if (j == n + 1) return -curr_row[n-1];
    return curr_row[j];
  endfunction

  // One explicit time step over the active length; returns the pickup item.
  function automatic pickup_t advance_string();
    int n;
    longint wc, sc, c0, l1, r1, d2, d4, d2h, d4h, d2l, d4l, hi, lo, v;
    bit sat;
    pickup_t res;
    n = eff_len(len_reg);
    wc = wave_reg;
    sc = stiff_reg;
    sat = 1'b0;
    for (int i = 0; i < n; i++) begin
      c0 = curr_row[i];
      l1 = curr_at(i - 1, n);
      r1 = curr_at(i + 1, n);
      d2 = l1 - 2 * c0 + r1;
      d4 = curr_at(i - 2, n) - 4 * l1 + 6 * c0 - 4 * r1 + curr_at(i + 2, n);
      // split the differences so the coefficient products fit in 64 bits
      d2h = d2 >>> FRAC_W;
      d4h = d4 >>> FRAC_W;
      d2l = d2 - (d2h <<< FRAC_W);
      d4l = d4 - (d4h <<< FRAC_W);
      hi = wc * d2h - sc * d4h;
      lo = wc * d2l - sc * d4l + (longint'(1) <<< (FRAC_W - 1));  // round half up
      v = hi + (lo >>> FRAC_W) + 2 * c0 - prev_row[i];
      if (v > DISP_MAX) begin
        v = DISP_MAX;
        sat = 1'b1;
      end else if (v < DISP_MIN) begin
        v = DISP_MIN;
        sat = 1'b1;
      end
      next_row[i] = v;
    end
    for (int i = 0; i < n; i++) begin
      prev_row[i] = curr_row[i];
      curr_row[i] = next_row[i];
    end
    res.disp = (pickup_reg < n) ? disp_t'(curr_row[pickup_reg]) : '0;
    res.sat = sat;
    return res;
  endfunction

  task automatic report(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Channel drivers. Inputs change at the falling edge, handshakes are seen at
  // the rising edge.
  // ---------------------------------------------------------------------------

  // Offer one item and hold it until accepted; valid stays high afterwards so
  // back-to-back items need no extra step.
  task automatic send_item(ssfd_cmd_e cmd, logic [IDX_W-1:0] idx, disp_t pv, disp_t cv);
    @(negedge clk_i);
    in_if.valid       = 1'b1;
    in_if.cmd         = cmd;
    in_if.point_index = idx;
    in_if.prev_value  = pv;
    in_if.curr_value  = cv;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (cmd == CMD_LOAD) begin
      prev_row[idx] = pv;
      curr_row[idx] = cv;
      n_loads++;
    end else begin
      pickup_q.insert(pickup_q.size(), advance_string());
      n_steps++;
    end
  endtask

  // random idle cycles before the next item
  task automatic sender_gap();
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
    end
  endtask

  task automatic write_reg(ssfd_reg_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_WAVE:   wave_reg = data;
      REG_STIFF:  stiff_reg = data;
      REG_PICKUP: pickup_reg = data[IDX_W-1:0];
      REG_LENGTH: len_reg = data[LEN_W-1:0];
    endcase
    n_cfg++;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Stop sending, let every owed result arrive, then a few idle cycles.
  task automatic wait_quiet();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pickup_q.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // Receiver: random stalls, or a long hold-off counted here in cycles.
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      out_if.ready = 1'b0;
      hold_left--;
    end else begin
      out_if.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready) begin
      if (pickup_q.size() == 0) begin
        report($sformatf("result 0x%08h arrived with no step pending", out_if.pickup_sample));
      end else begin
        got_exp = pickup_q.pop_front();
        if (out_if.pickup_sample !== got_exp.disp)
          report($sformatf("result %0d: pickup_sample 0x%08h, want 0x%08h",
                           n_results, out_if.pickup_sample, got_exp.disp));
        if (out_if.saturated !== got_exp.sat)
          report($sformatf("result %0d: saturated %b, want %b",
                           n_results, out_if.saturated, got_exp.sat));
        n_results++;
        if (got_exp.sat) n_sat++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values: full 2048-point string, pickup 1433, no stiffness.
  // The first items also wait out the clearing sweep.
  task automatic test_reset_defaults();
    send_item(CMD_LOAD, 11'd1433, 32'sh0000_0000, 32'sh1000_0000);
    send_item(CMD_LOAD, 11'd1434, 32'sh0800_0000, 32'sh0400_0000);
    send_item(CMD_STEP, '0, '0, '0);
    send_item(CMD_STEP, 11'h7FF, '1, '1);   // unused fields all ones
  endtask

  // Shortest string with stiffness on, so both one-sided stencils are hit;
  // pickup at the first and at the last point.
  task automatic test_end_stencils();
    wait_quiet();
    write_reg(REG_WAVE, 32'h0040_0000);
    write_reg(REG_STIFF, 32'h0010_0000);
    write_reg(REG_PICKUP, 32'd0);
    write_reg(REG_LENGTH, 32'd5);
    for (int k = 0; k < 5; k++)
      send_item(CMD_LOAD, IDX_W'(k), disp_t'(k * 32'sh0100_0000),
                disp_t'((k % 2 == 1) ? -(k + 1) * 32'sh0200_0000 : (k + 1) * 32'sh0200_0000));
    send_item(CMD_STEP, '0, '0, '0);
    wait_quiet();
    write_reg(REG_PICKUP, 32'd4);
    send_item(CMD_STEP, '0, '0, '0);
  endtask

  // Largest coefficients and extreme displacements: saturation on the result.
  // Length field zero (upper data bits set) clamps to the minimum; the load
  // beyond the active length must survive the steps untouched.
  task automatic test_saturation();
    wait_quiet();
    write_reg(REG_WAVE, 32'hFFFF_FFFF);
    write_reg(REG_STIFF, 32'hFFFF_FFFF);
    write_reg(REG_PICKUP, 32'd2);
    write_reg(REG_LENGTH, 32'hFFFF_F000);
    send_item(CMD_LOAD, 11'd0, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_item(CMD_LOAD, 11'd2, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_item(CMD_LOAD, 11'd4, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_item(CMD_LOAD, 11'd2047, 32'sh8000_0000, 32'sh8000_0000);
    send_item(CMD_STEP, '0, '0, '0);
    send_item(CMD_STEP, '0, '0, '0);
  endtask

  // Zero coefficients (pure 2c - p), length above the maximum clamps to 2048,
  // then a pickup beyond a short active length reads zero.
  task automatic test_length_limits();
    wait_quiet();
    write_reg(REG_WAVE, 32'd0);
    write_reg(REG_STIFF, 32'd0);
    write_reg(REG_PICKUP, 32'd2047);
    write_reg(REG_LENGTH, 32'd4095);
    send_item(CMD_LOAD, 11'd2047, 32'sh0100_0000, 32'sh0300_0000);
    send_item(CMD_STEP, '0, '0, '0);
    wait_quiet();
    write_reg(REG_LENGTH, 32'd5);
    send_item(CMD_STEP, '0, '0, '0);
  endtask

  // Segments of random traffic, each under a fresh random register setting:
  // mostly loads inside the active string followed by steps.
  task automatic test_random_traffic(int idle, int stall, int count);
    int sent, seg, n;
    logic [31:0] r;
    logic [LEN_W-1:0] len;
    logic [IDX_W-1:0] pick, idx;
    disp_t pv, cv;
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < count) begin
      wait_quiet();
      // mostly stable coefficients, now and then anything
      if ($urandom_range(3) == 0) write_reg(REG_WAVE, $urandom);
      else write_reg(REG_WAVE, $urandom_range(0, 32'h0080_0000));
      case ($urandom_range(3))
        0:       write_reg(REG_STIFF, $urandom);
        1:       write_reg(REG_STIFF, 32'd0);
        default: write_reg(REG_STIFF, $urandom_range(0, 32'h0004_0000));
      endcase
      // short strings keep steps cheap; clamped lengths now and then
      case ($urandom_range(15))
        0:       len = LEN_W'($urandom_range(0, 4));
        1:       len = LEN_W'($urandom_range(2048, 4095));
        default: len = LEN_W'($urandom_range(5, 40));
      endcase
      n = eff_len(len);
      pick = IDX_W'(($urandom_range(3) == 0) ? $urandom_range(0, 2047)
                                              : $urandom_range(0, n - 1));
      r = $urandom;
      write_reg(REG_LENGTH, {r[31:LEN_W], len});
      r = $urandom;
      write_reg(REG_PICKUP, {r[31:IDX_W], pick});
      seg = $urandom_range(10, 24);
      if (seg > count - sent) seg = count - sent;
      repeat (seg) begin
        sender_gap();
        pv = $urandom;
        cv = $urandom;
        if ($urandom_range(99) < 30) begin
          send_item(CMD_STEP, IDX_W'($urandom), pv, cv);
        end else begin
          idx = IDX_W'(($urandom_range(4) == 0) ? $urandom_range(0, 2047)
                                                 : $urandom_range(0, n - 1));
          pv = pv >>> $urandom_range(0, 8);
          cv = cv >>> $urandom_range(0, 8);
          send_item(CMD_LOAD, idx, pv, cv);
        end
        sent++;
      end
    end
  endtask

  // Receiver holds off long enough that a finished result blocks the next
  // step and the input stalls; after the drain, items run under random stalls.
  task automatic test_backpressure();
    disp_t pv, cv;
    idle_pct = 0;
    stall_pct = 0;
    wait_quiet();
    write_reg(REG_WAVE, 32'h0030_0000);
    write_reg(REG_STIFF, 32'h0002_0000);
    write_reg(REG_PICKUP, 32'd3);
    write_reg(REG_LENGTH, 32'd8);
    @(posedge clk_i);
    hold_req = HOLD_CYCLES;
    repeat (8) begin
      pv = $urandom;
      cv = $urandom;
      send_item(CMD_LOAD, IDX_W'($urandom_range(0, 7)), pv >>> 3, cv >>> 3);
      send_item(CMD_STEP, IDX_W'($urandom), pv, cv);
    end
    wait_quiet();
    stall_pct = 50;
    repeat (4) begin
      pv = $urandom;
      cv = $urandom;
      send_item(CMD_LOAD, IDX_W'($urandom_range(0, 7)), pv >>> 4, cv >>> 4);
      send_item(CMD_STEP, IDX_W'($urandom), pv, cv);
    end
  endtask

  initial begin
    in_if.valid       = 1'b0;
    in_if.cmd         = CMD_LOAD;
    in_if.point_index = '0;
    in_if.prev_value  = '0;
    in_if.curr_value  = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_WAVE;
    cfg_if.data       = '0;
    out_if.ready      = 1'b1;
    rst_ni            = 1'b0;
    repeat (RST_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_end_stencils();
    test_saturation();
    test_length_limits();
    test_random_traffic(0, 0, 62);
    test_random_traffic(74, 0, 62);
    test_random_traffic(0, 74, 62);
    test_random_traffic(24, 24, 62);
    test_backpressure();

    // drain, then give a stray late result time to show up
    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d loads and %0d steps under %0d register writes, incl. long hold-off",
             n_loads, n_steps, n_cfg);
    $display("Checked %0d pickup results (%0d saturated), %0d mismatches",
             n_results, n_sat, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT);
    $display("Run limit reached with %0d results still owed", pickup_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule
